### rtl/odm_pkg.sv
// Shared constants, register indexes, level codes and the configuration
// bundle for the occupancy density monitor.
// No dependencies.
package odm_pkg;

    // Default widths of the frame fields
    localparam int DEFAULT_COUNT_BITS = 8;
    localparam int DEFAULT_TIME_BITS  = 48;

    // Configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 17;
    localparam int THRESH_BITS    = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BLOCK_ENABLE     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEVERE_ENABLE    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEVERE_THRESHOLD = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MEDIUM_ENABLE    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MEDIUM_THRESHOLD = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_ENABLE    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NORMAL_THRESHOLD = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REPORT_INTERVAL  = 3'd7;

    // Time scaling
    localparam int MS_PER_SEC       = 1000;
    localparam int MS_BITS          = 10;   // bits of MS_PER_SEC
    localparam int INTERVAL_MS_BITS = 27;   // 131071 s * 1000 fits
    localparam logic [INTERVAL_MS_BITS-1:0] INTERVAL_RESET_MS = 27'd60000;

    // Accumulator and result widths
    localparam int OCC_BITS  = 64;
    localparam int STAY_BITS = 32;
    localparam int SEQ_BITS  = 32;
    localparam int ECHO_BITS = 8;
    localparam logic [OCC_BITS-1:0]  OCC_MAX  = '1;
    localparam logic [STAY_BITS-1:0] STAY_MAX = '1;

    // Density level codes
    localparam int LEVEL_BITS = 2;
    localparam logic [LEVEL_BITS-1:0] LEVEL_NONE   = 2'd0;
    localparam logic [LEVEL_BITS-1:0] LEVEL_NORMAL = 2'd1;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MEDIUM = 2'd2;
    localparam logic [LEVEL_BITS-1:0] LEVEL_SEVERE = 2'd3;

    // Depth of the queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    // Configuration seen by the back end
    typedef struct packed {
        logic                        clear;
        logic [INTERVAL_MS_BITS-1:0] interval_ms;
    } odm_cfg_t;

endpackage

### rtl/odm_front.sv
// Front end: configuration registers, frame transfer and density grading.
// Depends on odm_pkg.
module odm_front #(
    parameter int COUNT_BITS = odm_pkg::DEFAULT_COUNT_BITS,
    parameter int TIME_BITS  = odm_pkg::DEFAULT_TIME_BITS,
    localparam int ITEM_BITS = 1 + odm_pkg::LEVEL_BITS + COUNT_BITS + TIME_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [odm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [odm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [TIME_BITS-1:0]               now_ms,
    input  logic [COUNT_BITS-1:0]              people_count,
    output odm_pkg::odm_cfg_t                  cfg,
    output logic                               push,
    output logic [ITEM_BITS-1:0]               push_data,
    input  logic                               q_full
);
    import odm_pkg::*;

    localparam int CW = (COUNT_BITS > THRESH_BITS) ? COUNT_BITS : THRESH_BITS;

    logic                        block_enable_reg;
    logic                        severe_enable_reg;
    logic [THRESH_BITS-1:0]      severe_threshold_reg;
    logic                        medium_enable_reg;
    logic [THRESH_BITS-1:0]      medium_threshold_reg;
    logic                        normal_enable_reg;
    logic [THRESH_BITS-1:0]      normal_threshold_reg;
    logic [INTERVAL_MS_BITS-1:0] interval_ms_reg;
    logic [LEVEL_BITS-1:0]       level;
    logic [CW-1:0]               count_x;

    // Configuration registers; the interval is kept in milliseconds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_enable_reg     <= 1'b0;
            severe_enable_reg    <= 1'b0;
            severe_threshold_reg <= '0;
            medium_enable_reg    <= 1'b0;
            medium_threshold_reg <= '0;
            normal_enable_reg    <= 1'b0;
            normal_threshold_reg <= '0;
            interval_ms_reg      <= INTERVAL_RESET_MS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BLOCK_ENABLE:     block_enable_reg     <= cfg_data[0];
                REG_SEVERE_ENABLE:    severe_enable_reg    <= cfg_data[0];
                REG_SEVERE_THRESHOLD: severe_threshold_reg <= cfg_data[THRESH_BITS-1:0];
                REG_MEDIUM_ENABLE:    medium_enable_reg    <= cfg_data[0];
                REG_MEDIUM_THRESHOLD: medium_threshold_reg <= cfg_data[THRESH_BITS-1:0];
                REG_NORMAL_ENABLE:    normal_enable_reg    <= cfg_data[0];
                REG_NORMAL_THRESHOLD: normal_threshold_reg <= cfg_data[THRESH_BITS-1:0];
                REG_REPORT_INTERVAL:
                begin
                    // a zero interval keeps the old one
                    if (cfg_data != '0)
                    begin
                        interval_ms_reg <= INTERVAL_MS_BITS'(cfg_data)
                                         * INTERVAL_MS_BITS'(MS_PER_SEC);
                    end
                end
                default: ;
            endcase
        end
    end

    // Clear pulse on a write of zero to the enable register
    assign cfg.clear       = cfg_write && (cfg_index == REG_BLOCK_ENABLE) && !cfg_data[0];
    assign cfg.interval_ms = interval_ms_reg;

    // Grading: severe first, then medium, then normal
    assign count_x = CW'(people_count);

    always_comb
    begin
        if (severe_enable_reg && count_x >= CW'(severe_threshold_reg))
            level = LEVEL_SEVERE;
        else if (medium_enable_reg && count_x >= CW'(medium_threshold_reg))
            level = LEVEL_MEDIUM;
        else if (normal_enable_reg && count_x >= CW'(normal_threshold_reg))
            level = LEVEL_NORMAL;
        else
            level = LEVEL_NONE;
    end

    // Frame transfer into the queue
    assign in_stall  = q_full;
    assign push      = in_valid && !q_full;
    assign push_data = {block_enable_reg, level, people_count, now_ms};

endmodule

### rtl/odm_queue.sv
// Small FIFO between the front and back end.
// Depends on odm_pkg for the default depth.
module odm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = odm_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] fill_reg;

    assign full     = (fill_reg == CNT_BITS'(DEPTH));
    assign valid    = (fill_reg != '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/odm_back.sv
// Back end: occupancy integration, report timing, average-stay divider
// and the output register. Depends on odm_pkg.
module odm_back #(
    parameter int COUNT_BITS = odm_pkg::DEFAULT_COUNT_BITS,
    parameter int TIME_BITS  = odm_pkg::DEFAULT_TIME_BITS,
    localparam int ITEM_BITS = 1 + odm_pkg::LEVEL_BITS + COUNT_BITS + TIME_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  odm_pkg::odm_cfg_t              cfg,
    input  logic                           q_valid,
    input  logic [ITEM_BITS-1:0]           q_data,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           active,
    output logic [odm_pkg::LEVEL_BITS-1:0] level,
    output logic                           report_due,
    output logic [odm_pkg::SEQ_BITS-1:0]   report_seq,
    output logic [odm_pkg::ECHO_BITS-1:0]  current_count,
    output logic [odm_pkg::STAY_BITS-1:0]  mean_stay_sec
);
    import odm_pkg::*;

    localparam int PW      = TIME_BITS + COUNT_BITS;
    localparam int XW      = (PW > OCC_BITS) ? PW : OCC_BITS;
    localparam int DVW     = COUNT_BITS + MS_BITS;
    localparam int DCNT_W  = $clog2(OCC_BITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SAT  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_RPT  = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    // Fields of a queued frame
    logic                  q_en;
    logic [LEVEL_BITS-1:0] q_level;
    logic [COUNT_BITS-1:0] q_count;
    logic [TIME_BITS-1:0]  q_now;

    // Control and running state
    logic [2:0]            state_reg, state_next;
    logic [TIME_BITS-1:0]  last_sample_reg, last_sample_next;
    logic [COUNT_BITS-1:0] last_count_reg, last_count_next;
    logic [COUNT_BITS-1:0] peak_reg, peak_next;
    logic [OCC_BITS-1:0]   occ_reg, occ_next;
    logic [TIME_BITS-1:0]  last_report_reg, last_report_next;
    logic [SEQ_BITS-1:0]   seq_reg, seq_next;
    logic                  out_valid_reg, out_valid_next;

    // Per-frame working registers
    logic [TIME_BITS-1:0]  now_reg, now_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [LEVEL_BITS-1:0] level_reg, level_next;
    logic                  act_reg, act_next;
    logic                  rpt_reg, rpt_next;
    logic [PW-1:0]         mcand_reg, mcand_next;
    logic [COUNT_BITS-1:0] mplier_reg, mplier_next;
    logic [PW-1:0]         prod_reg, prod_next;
    logic [OCC_BITS-1:0]   add_reg, add_next;
    logic [DVW-1:0]        divisor_reg, divisor_next;
    logic [DVW-1:0]        rem_reg, rem_next;
    logic [OCC_BITS-1:0]   quo_reg, quo_next;
    logic [DCNT_W-1:0]     div_cnt_reg, div_cnt_next;

    // Output register
    logic                  out_active_reg, out_active_next;
    logic [LEVEL_BITS-1:0] out_level_reg, out_level_next;
    logic                  out_rpt_reg, out_rpt_next;
    logic [SEQ_BITS-1:0]   out_seq_reg, out_seq_next;
    logic [ECHO_BITS-1:0]  out_count_reg, out_count_next;
    logic [STAY_BITS-1:0]  out_stay_reg, out_stay_next;

    // Datapath helpers
    logic [XW-1:0]         prod_x;
    logic [OCC_BITS:0]     occ_sum;
    logic [DVW:0]          trial;
    logic [TIME_BITS-1:0]  since_report;
    logic [STAY_BITS-1:0]  stay_capped;

    assign {q_en, q_level, q_count, q_now} = q_data;

    assign prod_x       = XW'(prod_reg);
    assign occ_sum      = {1'b0, occ_reg} + {1'b0, add_reg};
    assign trial        = {rem_reg, quo_reg[OCC_BITS-1]};
    assign since_report = now_reg - last_report_reg;
    assign stay_capped  = (quo_reg[OCC_BITS-1:STAY_BITS] != '0) ? STAY_MAX
                                                                : quo_reg[STAY_BITS-1:0];

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        last_sample_next = last_sample_reg;
        last_count_next  = last_count_reg;
        peak_next        = peak_reg;
        occ_next         = occ_reg;
        last_report_next = last_report_reg;
        seq_next         = seq_reg;
        now_next         = now_reg;
        cnt_next         = cnt_reg;
        level_next       = level_reg;
        act_next         = act_reg;
        rpt_next         = rpt_reg;
        mcand_next       = mcand_reg;
        mplier_next      = mplier_reg;
        prod_next        = prod_reg;
        add_next         = add_reg;
        divisor_next     = divisor_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        div_cnt_next     = div_cnt_reg;
        out_active_next  = out_active_reg;
        out_level_next   = out_level_reg;
        out_rpt_next     = out_rpt_reg;
        out_seq_next     = out_seq_reg;
        out_count_next   = out_count_reg;
        out_stay_next    = out_stay_reg;
        q_pop            = 1'b0;

        // result leaves on a completed transfer
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    now_next   = q_now;
                    cnt_next   = q_count;
                    level_next = q_level;
                    act_next   = q_en;
                    rpt_next   = 1'b0;
                    if (!q_en)
                    begin
                        state_next = ST_FIN;
                    end
                    else if (last_sample_reg == '0)
                    begin
                        // first sample: nothing to integrate
                        last_sample_next = q_now;
                        last_count_next  = q_count;
                        peak_next        = q_count;
                        state_next       = ST_RPT;
                    end
                    else if (q_now < last_sample_reg)
                    begin
                        // time went backwards: restart the stay
                        occ_next         = '0;
                        last_count_next  = q_count;
                        peak_next        = q_count;
                        last_sample_next = q_now;
                        state_next       = ST_RPT;
                    end
                    else
                    begin
                        mcand_next       = PW'(q_now - last_sample_reg);
                        mplier_next      = last_count_reg;
                        prod_next        = '0;
                        if (q_count > peak_reg)
                            peak_next = q_count;
                        last_sample_next = q_now;
                        last_count_next  = q_count;
                        state_next       = ST_MUL;
                    end
                end
            end

            ST_MUL:
            begin
                // shift-add over the bits of the previous count
                if (mplier_reg == '0)
                begin
                    state_next = ST_SAT;
                end
                else
                begin
                    if (mplier_reg[0])
                        prod_next = prod_reg + mcand_reg;
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end

            ST_SAT:
            begin
                add_next   = (prod_x > XW'(OCC_MAX)) ? OCC_MAX : prod_x[OCC_BITS-1:0];
                state_next = ST_SUM;
            end

            ST_SUM:
            begin
                occ_next   = occ_sum[OCC_BITS] ? OCC_MAX : occ_sum[OCC_BITS-1:0];
                state_next = ST_RPT;
            end

            ST_RPT:
            begin
                state_next = ST_FIN;
                if (last_report_reg == '0)
                begin
                    last_report_next = now_reg;
                end
                else if (!(now_reg < last_report_reg)
                         && !(since_report < TIME_BITS'(cfg.interval_ms)))
                begin
                    last_report_next = now_reg;
                    seq_next         = seq_reg + 1'b1;
                    rpt_next         = 1'b1;
                    // restart the stay after the report
                    occ_next         = '0;
                    last_count_next  = cnt_reg;
                    peak_next        = cnt_reg;
                    if (peak_reg == '0 || occ_reg == '0)
                    begin
                        quo_next = '0;
                    end
                    else
                    begin
                        // occ / peak / 1000 == occ / (peak * 1000)
                        divisor_next = DVW'(peak_reg) * DVW'(MS_PER_SEC);
                        rem_next     = '0;
                        quo_next     = occ_reg;
                        div_cnt_next = '0;
                        state_next   = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                // restoring divider, one quotient bit per cycle
                if (trial >= {1'b0, divisor_reg})
                begin
                    rem_next = DVW'(trial - {1'b0, divisor_reg});
                    quo_next = {quo_reg[OCC_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DVW-1:0];
                    quo_next = {quo_reg[OCC_BITS-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DCNT_W'(OCC_BITS - 1))
                    state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_active_next = act_reg;
                    out_level_next  = act_reg ? level_reg : LEVEL_NONE;
                    out_rpt_next    = rpt_reg;
                    out_seq_next    = rpt_reg ? seq_reg : '0;
                    out_count_next  = rpt_reg ? ECHO_BITS'(cnt_reg) : '0;
                    out_stay_next   = rpt_reg ? stay_capped : '0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // disable clears the running state
        if (cfg.clear)
        begin
            last_sample_next = '0;
            last_count_next  = '0;
            peak_next        = '0;
            occ_next         = '0;
            last_report_next = '0;
            seq_next         = '0;
        end
    end

    // Control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            last_sample_reg <= '0;
            last_count_reg  <= '0;
            peak_reg        <= '0;
            occ_reg         <= '0;
            last_report_reg <= '0;
            seq_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            last_sample_reg <= last_sample_next;
            last_count_reg  <= last_count_next;
            peak_reg        <= peak_next;
            occ_reg         <= occ_next;
            last_report_reg <= last_report_next;
            seq_reg         <= seq_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Working and output payload
    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        cnt_reg        <= cnt_next;
        level_reg      <= level_next;
        act_reg        <= act_next;
        rpt_reg        <= rpt_next;
        mcand_reg      <= mcand_next;
        mplier_reg     <= mplier_next;
        prod_reg       <= prod_next;
        add_reg        <= add_next;
        divisor_reg    <= divisor_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        div_cnt_reg    <= div_cnt_next;
        out_active_reg <= out_active_next;
        out_level_reg  <= out_level_next;
        out_rpt_reg    <= out_rpt_next;
        out_seq_reg    <= out_seq_next;
        out_count_reg  <= out_count_next;
        out_stay_reg   <= out_stay_next;
    end

    assign out_valid     = out_valid_reg;
    assign active        = out_active_reg;
    assign level         = out_level_reg;
    assign report_due    = out_rpt_reg;
    assign report_seq    = out_seq_reg;
    assign current_count = out_count_reg;
    assign mean_stay_sec = out_stay_reg;

endmodule

### rtl/occupancy_density_monitor.sv
// Top level of the occupancy density monitor.
// Depends on odm_pkg, odm_front, odm_queue and odm_back.
//
// Each transfer on the input channel is one frame (timestamp in ms and a
// head count) and gives exactly one result transfer: the density level and,
// on report frames, a sequence number, the echoed count and the average
// stay in seconds. The front end grades a frame in the cycle it is taken and
// drops it into a two-entry queue; the back end works one frame at a time.
// The back end's shift-add multiplier takes one step per significant bit of
// the previous count, and a report frame also runs the divider that forms
// the average stay, one quotient bit per cycle. The output register lets
// the back end finish the next frame while a result waits. Configuration is
// written through cfg_write, cfg_index and cfg_data; the user must write it
// only while no frame is in flight, and the block does not enforce this.
module occupancy_density_monitor #(
    parameter int COUNT_BITS = odm_pkg::DEFAULT_COUNT_BITS,
    parameter int TIME_BITS  = odm_pkg::DEFAULT_TIME_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [odm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [odm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [TIME_BITS-1:0]               now_ms,
    input  logic [COUNT_BITS-1:0]              people_count,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               active,
    output logic [odm_pkg::LEVEL_BITS-1:0]     level,
    output logic                               report_due,
    output logic [odm_pkg::SEQ_BITS-1:0]       report_seq,
    output logic [odm_pkg::ECHO_BITS-1:0]      current_count,
    output logic [odm_pkg::STAY_BITS-1:0]      mean_stay_sec
);
    import odm_pkg::*;

    localparam int ITEM_BITS = 1 + LEVEL_BITS + COUNT_BITS + TIME_BITS;

    odm_cfg_t             cfg;
    logic                 push;
    logic [ITEM_BITS-1:0] push_data;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    logic [ITEM_BITS-1:0] q_data;

    // Configuration, grading and frame transfer
    odm_front #(
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .now_ms       (now_ms),
        .people_count (people_count),
        .cfg          (cfg),
        .push         (push),
        .push_data    (push_data),
        .q_full       (q_full)
    );

    // Decoupling queue
    odm_queue #(
        .WIDTH (ITEM_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    // Integration, reports and result
    odm_back #(
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .active        (active),
        .level         (level),
        .report_due    (report_due),
        .report_seq    (report_seq),
        .current_count (current_count),
        .mean_stay_sec (mean_stay_sec)
    );

endmodule

### rtl/odm_checker.sv
// Port-level checks for the occupancy density monitor, bound to the top.
// Depends on odm_pkg and occupancy_density_monitor.
module odm_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic                               active,
    input  logic [odm_pkg::LEVEL_BITS-1:0]     level,
    input  logic                               report_due,
    input  logic [odm_pkg::SEQ_BITS-1:0]       report_seq,
    input  logic [odm_pkg::ECHO_BITS-1:0]      current_count,
    input  logic [odm_pkg::STAY_BITS-1:0]      mean_stay_sec
);
    import odm_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(level) && $stable(report_due)
            && $stable(report_seq) && $stable(mean_stay_sec))
        else $error("result changed while stalled");

    // Inactive frames give an all-zero result
    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !active |-> level == LEVEL_NONE && !report_due
            && report_seq == '0 && current_count == '0 && mean_stay_sec == '0)
        else $error("inactive result not zero");

    // Report fields are zero off report frames
    a_no_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !report_due |-> report_seq == '0 && current_count == '0
            && mean_stay_sec == '0)
        else $error("report fields set without report");

    // A report only comes from an active frame
    a_report_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && report_due |-> active)
        else $error("report on inactive frame");

endmodule

bind occupancy_density_monitor odm_checker u_odm_checker (.*);
